FILE: rtl/pida_pkg.sv
`default_nettype none

package pida_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int CNT_W        = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int SEL_GRP      = 8;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
		logic [CNT_W-1:0]   occ;
		logic [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pida_cell.sv
`default_nettype none

module pida_cell #(
	parameter int IDX = 0
) (
	input  wire logic                        clk,
	input  wire pida_pkg::cell_ctrl_t        ctrl,
	input  wire logic [pida_pkg::DATA_W-1:0] left_word,
	input  wire logic [pida_pkg::DATA_W-1:0] right_word,
	input  wire logic [pida_pkg::DATA_W-1:0] first_word,
	output logic      [pida_pkg::DATA_W-1:0] word,
	output logic      [pida_pkg::DATA_W-1:0] pick
);

	localparam logic [pida_pkg::POS_W-1:0] IDX_C  = pida_pkg::POS_W'(IDX);
	localparam logic [pida_pkg::CNT_W-1:0] NEXT_C = pida_pkg::CNT_W'(IDX + 1);

	logic [pida_pkg::DATA_W-1:0] word_q;
	logic [pida_pkg::DATA_W-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (ctrl.op)
			pida_pkg::OP_INS: begin
				if (IDX_C > ctrl.pos) begin
					word_d = left_word;
				end else if (IDX_C == ctrl.pos) begin
					word_d = ctrl.value;
				end
			end
			pida_pkg::OP_DEL: begin
				if (IDX_C >= ctrl.pos) begin
					word_d = right_word;
				end
			end
			pida_pkg::OP_ROT: begin
				if (NEXT_C == ctrl.occ) begin
					word_d = first_word;
				end else if (NEXT_C < ctrl.occ) begin
					word_d = right_word;
				end
			end
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
	assign pick = (IDX_C == ctrl.pos) ? word_q : '0;

endmodule

`default_nettype wire

FILE: rtl/pida_sel.sv
`default_nettype none

module pida_sel #(
	parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
	input  wire logic                                     clk,
	input  wire logic [CAPACITY-1:0][pida_pkg::DATA_W-1:0] picks,
	output logic      [pida_pkg::DATA_W-1:0]              taken
);

	localparam int GRP  = pida_pkg::SEL_GRP;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	logic [NGRP*GRP-1:0][pida_pkg::DATA_W-1:0] padded;
	logic [NGRP-1:0][pida_pkg::DATA_W-1:0]     grp_d;
	logic [NGRP-1:0][pida_pkg::DATA_W-1:0]     grp_s1;

	assign padded = (NGRP*GRP*pida_pkg::DATA_W)'(picks);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				grp_d[g] = grp_d[g] | padded[g*GRP + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	always_comb begin
		taken = '0;
		for (int g = 0; g < NGRP; g++) begin
			taken = taken | grp_s1[g];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/positional_insert_delete_array.sv
// Packed array of signed words with insert, delete and display at a position.
// Input channel s_axis: one transaction per command; tuser holds the command
// (insert, delete, display), tdata holds the value and the position.
// Output channel m_axis: tuser holds the status, tdata the data word and the
// entry count after the command, tlast marks the final result of a command.
// Storage is a row of cells; the cells from the position on take a neighbor's
// word or the new value, all in the same cycle, so insert and delete shift
// the array at once. Insert and failed commands give their result in the
// cycle after the input transaction; a delete passes through the registered
// selection tree that picks the removed word, then the output register.
// Display loads one entry per cycle from the display state while the output
// is not stalled, rotating the row of cells once around. One command is
// handled at a time: the next input transaction is taken once the last
// result of the previous command sits in the output register and that
// register is free or being drained in the same cycle. Back-to-back inserts
// therefore run at one per cycle while m_axis_tready is high; a delete holds
// off the next command until its result is loaded. Reset empties the array
// (count zero); stored words are not cleared. When the receiver holds
// m_axis_tready low the result holds and the block stalls, taking no input.
`default_nettype none

module positional_insert_delete_array #(
	parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // value[31:0], position[38:32], zero[39]
	input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,  // data[31:0], count[38:32], zero[39]
	output logic      [1:0]  m_axis_tuser,  // status[1:0]
	output logic             m_axis_tlast
);

	localparam int DATA_W = pida_pkg::DATA_W;
	localparam int POS_W  = pida_pkg::POS_W;
	localparam int CNT_W  = pida_pkg::CNT_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_DISPLAY = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY,
		STAT_BADPOS
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEL,
		ST_DISP
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              occ_q;
	logic [CNT_W-1:0]              idx_q;
	logic                          out_valid_q;
	status_t                       out_status_q;
	logic [DATA_W-1:0]             out_data_q;
	logic [CNT_W-1:0]              out_count_q;
	logic                          out_last_q;

	logic signed [DATA_W-1:0]      in_value;
	logic [POS_W-1:0]              in_pos;
	logic [1:0]                    in_cmd;
	logic                          out_free;
	logic                          out_load;
	logic                          s_acc;
	logic                          ins_ok;
	logic                          del_ok;
	logic                          disp_last;
	pida_pkg::cell_ctrl_t          ctrl;
	logic [CAPACITY-1:0][DATA_W-1:0] words;
	logic [CAPACITY-1:0][DATA_W-1:0] picks;
	logic [DATA_W-1:0]             taken;

	assign in_value  = s_axis_tdata[31:0];
	assign in_pos    = s_axis_tdata[38:32];
	assign in_cmd    = s_axis_tuser;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign ins_ok    = (occ_q != CAP_C) && (in_pos <= occ_q);
	assign del_ok    = (occ_q != '0) && (in_pos < occ_q);
	assign disp_last = (idx_q + ONE_C) == occ_q;
	assign out_load  = s_acc ?
		!((in_cmd == CMD_DELETE && del_ok) || (in_cmd == CMD_DISPLAY && occ_q != '0)) :
		((state_q == ST_DEL || state_q == ST_DISP) && out_free);

	always_comb begin
		ctrl.op    = pida_pkg::OP_HOLD;
		ctrl.pos   = in_pos;
		ctrl.occ   = occ_q;
		ctrl.value = in_value;
		if (s_acc && in_cmd == CMD_INSERT && ins_ok) begin
			ctrl.op = pida_pkg::OP_INS;
		end else if (s_acc && in_cmd == CMD_DELETE && del_ok) begin
			ctrl.op = pida_pkg::OP_DEL;
		end else if (state_q == ST_DISP && out_free) begin
			ctrl.op = pida_pkg::OP_ROT;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_word;
		logic [DATA_W-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = words[0];
		end else begin : g_mid
			assign left_word = words[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_word = words[CAPACITY-1];
		end else begin : g_inner
			assign right_word = words[i+1];
		end

		pida_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_word  (left_word),
			.right_word (right_word),
			.first_word (words[0]),
			.word       (words[i]),
			.pick       (picks[i])
		);
	end

	pida_sel #(
		.CAPACITY(CAPACITY)
	) u_sel (
		.clk   (clk),
		.picks (picks),
		.taken (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occ_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STAT_OK;
			out_data_q   <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						out_data_q <= '0;
						out_last_q <= 1'b1;
						if (in_cmd == CMD_INSERT && ins_ok) begin
							out_count_q <= occ_q + ONE_C;
						end else begin
							out_count_q <= occ_q;
						end
						case (in_cmd)
							CMD_INSERT: begin
								if (occ_q == CAP_C) begin
									out_status_q <= STAT_FULL;
								end else if (!ins_ok) begin
									out_status_q <= STAT_BADPOS;
								end else begin
									out_status_q <= STAT_OK;
									occ_q        <= occ_q + ONE_C;
								end
							end
							CMD_DELETE: begin
								if (occ_q == '0) begin
									out_status_q <= STAT_EMPTY;
								end else if (!del_ok) begin
									out_status_q <= STAT_BADPOS;
								end else begin
									occ_q   <= occ_q - ONE_C;
									state_q <= ST_DEL;
								end
							end
							CMD_DISPLAY: begin
								if (occ_q == '0) begin
									out_status_q <= STAT_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= ST_DISP;
								end
							end
							default: begin
								out_status_q <= STAT_BADPOS;
							end
						endcase
					end
				end
				ST_DEL: begin
					if (out_free) begin
						out_status_q <= STAT_OK;
						out_data_q   <= taken;
						out_count_q  <= occ_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_DISP: begin
					if (out_free) begin
						out_status_q <= STAT_OK;
						out_data_q   <= words[0];
						out_count_q  <= occ_q;
						out_last_q   <= disp_last;
						idx_q        <= idx_q + ONE_C;
						if (disp_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_data_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP_C)
		else $error("occupancy above capacity");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && in_cmd == CMD_DELETE && del_ok) |=> (occ_q == $past(occ_q) - ONE_C))
		else $error("delete did not reduce occupancy");

	a_disp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISP) |-> (occ_q != '0 && idx_q < occ_q))
		else $error("display past stored entries");

	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_count_q <= CAP_C))
		else $error("reported count above capacity");

endmodule

`default_nettype wire
